// ===== rtl/fsgc_pkg.sv =====
package fsgc_pkg;

  // Verdict codes carried on each result word.
  localparam logic [2:0] VERDICT_IN_SEQ    = 3'd0;
  localparam logic [2:0] VERDICT_DUPLICATE = 3'd1;
  localparam logic [2:0] VERDICT_GAP       = 3'd2;
  localparam logic [2:0] VERDICT_REORDER   = 3'd3;
  localparam logic [2:0] VERDICT_FULL      = 3'd4;
  localparam logic [2:0] VERDICT_SEQ_MAX   = 3'd5;

  // One packet header as it moves from the front part to the back part.
  typedef struct packed {
    logic [15:0] venue_id;
    logic [15:0] channel_num;
    logic [63:0] seq_num;
    logic [63:0] stamp_ns;
    logic        after_stale_gap;
  } pkt_t;

  // One result word.
  typedef struct packed {
    logic [2:0]  verdict;
    logic        stale_hit;
    logic        apply_ok;
    logic [5:0]  slot_index;
    logic [31:0] duplicates_seen;
    logic [31:0] gaps_seen;
    logic [31:0] reorders_seen;
    logic [31:0] stales_seen;
  } res_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ===== rtl/fsgc_front.sv =====
// Front part: a two-entry queue of packet headers that takes words from the
// input port and hands them to the back part one at a time.
module fsgc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  fsgc_pkg::pkt_t push_pkt,
  output logic          pkt_valid,
  output fsgc_pkg::pkt_t pkt,
  input  logic          pkt_take
);

  fsgc_pkg::pkt_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign full      = (count == 2'd2);
  assign pkt_valid = (count != 2'd0);
  assign pkt       = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pkt_take && pkt_valid;

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_pkt;
  end

  assert property (@(posedge clk) disable iff (rst) !(count == 2'd2 && do_push))
    else $error("queue overrun");
  assert property (@(posedge clk) disable iff (rst) !(count == 2'd0 && do_pop))
    else $error("queue underrun");
  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 2'd1)
    else $error("count lost a push");

endmodule

// ===== rtl/fsgc_back.sv =====
// Back part: channel lookup, classification and table update.
// Per packet: IDLE takes a word from the queue, MATCH compares the key against
// every entry and reads the matched entry, UPDATE classifies, writes back and
// emits the result, waiting while an earlier result has not been taken.
module fsgc_back #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [63:0]    stale_limit,
  input  logic           pkt_valid,
  input  fsgc_pkg::pkt_t pkt,
  output logic           pkt_take,
  output logic           res_valid,
  output fsgc_pkg::res_t res,
  input  logic           res_take
);

  localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW = $clog2(MAX_CHANNELS + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  // Key store (flops, compared in parallel) and data store (memory).
  logic [15:0] key_venue [MAX_CHANNELS];
  logic [15:0] key_chan  [MAX_CHANNELS];
  logic [63:0] mem_seq   [MAX_CHANNELS];
  logic [63:0] mem_time  [MAX_CHANNELS];
  logic        mem_ok    [MAX_CHANNELS];

  logic [1:0]    state;
  logic [CW-1:0] used;
  logic [31:0]   dup_total;
  logic [31:0]   gap_total;
  logic [31:0]   reorder_total;
  logic [31:0]   stale_total;
  fsgc_pkg::pkt_t cur;
  logic [IW-1:0] slot;
  logic          hit;
  logic          fresh;
  logic [63:0]   rd_seq;
  logic [63:0]   rd_time;
  logic          rd_ok;

  logic          m_found;
  logic [IW-1:0] m_idx;
  logic          room;

  // Parallel match: the lowest matching allocated entry wins.
  always_comb begin
    m_found = 1'b0;
    m_idx   = '0;
    for (int i = MAX_CHANNELS - 1; i >= 0; i--) begin
      if (CW'(i) < used && key_venue[i] == cur.venue_id &&
          key_chan[i] == cur.channel_num) begin
        m_found = 1'b1;
        m_idx   = IW'(i);
      end
    end
  end
  assign room = (used < CW'(MAX_CHANNELS));

  // Classification of the packet against the entry read in MATCH.
  logic [63:0] last_eff;
  logic [63:0] time_eff;
  logic        ok_eff;
  logic        is_dup;
  logic        is_max;
  logic        is_gap;
  logic        is_ro;
  logic        go_on;
  logic        late;
  logic        stale;
  logic [63:0] tdiff;
  logic [2:0]  verdict;

  always_comb begin
    last_eff = fresh ? 64'd0 : rd_seq;
    time_eff = fresh ? 64'd0 : rd_time;
    ok_eff   = fresh ? 1'b1 : rd_ok;
    is_dup   = (last_eff != 64'd0) && (cur.seq_num == last_eff);
    is_max   = !is_dup && (last_eff == '1);
    is_gap   = !is_dup && !is_max && (last_eff != 64'd0) &&
               (cur.seq_num > last_eff + 64'd1);
    is_ro    = !is_dup && !is_max && (last_eff != 64'd0) &&
               (cur.seq_num < last_eff + 64'd1);
    go_on    = hit && !is_dup && !is_max && !is_ro;
    tdiff    = cur.stamp_ns - time_eff;
    late     = (time_eff != 64'd0) && ($signed(cur.stamp_ns) > $signed(time_eff)) &&
               (tdiff > stale_limit);
    stale    = go_on && (late || cur.after_stale_gap);
    if (!hit) verdict = fsgc_pkg::VERDICT_FULL;
    else if (is_dup) verdict = fsgc_pkg::VERDICT_DUPLICATE;
    else if (is_max) verdict = fsgc_pkg::VERDICT_SEQ_MAX;
    else if (is_gap) verdict = fsgc_pkg::VERDICT_GAP;
    else if (is_ro) verdict = fsgc_pkg::VERDICT_REORDER;
    else verdict = fsgc_pkg::VERDICT_IN_SEQ;
  end

  assign pkt_take = (state == ST_IDLE) && pkt_valid;

  // Sequencer, totals and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      used          <= '0;
      dup_total     <= '0;
      gap_total     <= '0;
      reorder_total <= '0;
      stale_total   <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (state == ST_UPDATE && (!res_valid || res_take)) res_valid <= 1'b1;
      else if (res_take) res_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pkt_valid) state <= ST_MATCH;
        end
        ST_MATCH: begin
          if (!m_found && room) used <= used + CW'(1);
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (!res_valid || res_take) begin
            if (hit && is_dup) dup_total <= fsgc_pkg::sat_inc(dup_total);
            if (hit && is_gap) gap_total <= fsgc_pkg::sat_inc(gap_total);
            if (hit && is_ro) reorder_total <= fsgc_pkg::sat_inc(reorder_total);
            if (stale) stale_total <= fsgc_pkg::sat_inc(stale_total);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result word payload.
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE && (!res_valid || res_take)) begin
      res.verdict         <= verdict;
      res.stale_hit       <= stale;
      res.apply_ok        <= go_on && ok_eff && !is_gap;
      res.slot_index      <= hit ? 6'(slot) : 6'd0;
      res.duplicates_seen <= (hit && is_dup) ? fsgc_pkg::sat_inc(dup_total) : dup_total;
      res.gaps_seen       <= (hit && is_gap) ? fsgc_pkg::sat_inc(gap_total) : gap_total;
      res.reorders_seen   <= (hit && is_ro) ? fsgc_pkg::sat_inc(reorder_total)
                                            : reorder_total;
      res.stales_seen     <= stale ? fsgc_pkg::sat_inc(stale_total) : stale_total;
    end
  end

  // Packet capture, lookup and table writes.
  always_ff @(posedge clk) begin
    if (pkt_take) cur <= pkt;
    if (state == ST_MATCH) begin
      hit     <= m_found || room;
      fresh   <= !m_found;
      slot    <= m_found ? m_idx : IW'(used);
      rd_seq  <= mem_seq[m_idx];
      rd_time <= mem_time[m_idx];
      rd_ok   <= mem_ok[m_idx];
      if (!m_found && room) begin
        key_venue[IW'(used)] <= cur.venue_id;
        key_chan[IW'(used)]  <= cur.channel_num;
      end
    end
    if (state == ST_UPDATE && (!res_valid || res_take) && hit && !is_dup && !is_max) begin
      mem_ok[slot] <= ok_eff && !is_gap && !is_ro;
      if (go_on) begin
        mem_seq[slot]  <= cur.seq_num;
        mem_time[slot] <= cur.stamp_ns;
      end else if (fresh) begin
        mem_seq[slot]  <= 64'd0;
        mem_time[slot] <= 64'd0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) used <= CW'(MAX_CHANNELS))
    else $error("allocation beyond table");
  assert property (@(posedge clk) disable iff (rst) state == ST_MATCH |=> state == ST_UPDATE)
    else $error("match not followed by update");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && !hit) |-> !stale)
    else $error("stale counted on full table");

endmodule

// ===== rtl/feed_sequence_gap_checker_top.sv =====
// Channel    Handshake        Word
// input      push / full      venue_id, channel_num, seq_num, stamp_ns, after_stale_gap
// result     pop / empty      verdict, stale_hit, apply_ok, slot_index, four totals
// config     cfg_valid/ready  stale_limit
//
// Each packet passes the take, match and update steps in the back part.
// The parallel key match and the one table read happen in the match step.
// A two-word input queue lets packets arrive while a result waits for pop.
// A stalled result holds the back part in its update step.
// Reset (rst, synchronous) empties the table and clears the totals.
module feed_sequence_gap_checker_top #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] venue_id,
  input  logic [15:0] channel_num,
  input  logic [63:0] seq_num,
  input  logic [63:0] stamp_ns,
  input  logic        after_stale_gap,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  verdict,
  output logic        stale_hit,
  output logic        apply_ok,
  output logic [5:0]  slot_index,
  output logic [31:0] duplicates_seen,
  output logic [31:0] gaps_seen,
  output logic [31:0] reorders_seen,
  output logic [31:0] stales_seen,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  fsgc_pkg::pkt_t in_pkt;
  fsgc_pkg::pkt_t q_pkt;
  fsgc_pkg::res_t res;
  logic           q_valid;
  logic           q_take;
  logic           res_valid;
  logic [63:0]    stale_limit;

  assign in_pkt = '{venue_id, channel_num, seq_num, stamp_ns, after_stale_gap};

  // Threshold register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) stale_limit <= 64'd0;
    else if (cfg_valid) stale_limit <= cfg_data;
  end

  fsgc_front u_front (
    .clk, .rst, .push, .full, .push_pkt(in_pkt),
    .pkt_valid(q_valid), .pkt(q_pkt), .pkt_take(q_take)
  );

  fsgc_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
    .clk, .rst, .stale_limit, .pkt_valid(q_valid), .pkt(q_pkt),
    .pkt_take(q_take), .res_valid, .res, .res_take(pop)
  );

  assign empty           = !res_valid;
  assign verdict         = res.verdict;
  assign stale_hit       = res.stale_hit;
  assign apply_ok        = res.apply_ok;
  assign slot_index      = res.slot_index;
  assign duplicates_seen = res.duplicates_seen;
  assign gaps_seen       = res.gaps_seen;
  assign reorders_seen   = res.reorders_seen;
  assign stales_seen     = res.stales_seen;

endmodule
